// ----- rtl/rahht_pkg.sv -----
// Shared types and constants for the row activation heavy-hitter tracker.
// Holds the field widths, default sizes and request codes; no dependencies.
package rahht_pkg;

    // Fixed field widths of the request and configuration ports.
    localparam int ACTION_W = 2;
    localparam int ROW_W    = 16;
    localparam int BANK_W   = 4;
    localparam int RANK_W   = 1;
    localparam int CHAN_W   = 1;
    localparam int THR_W    = 24;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1024);

    // Default table geometry.
    localparam int DEF_NUM_ENTRIES  = 64;
    localparam int DEF_NUM_ROWS     = 65536;
    localparam int DEF_NUM_BANKS    = 16;
    localparam int DEF_NUM_RANKS    = 2;
    localparam int DEF_NUM_CHANNELS = 2;
    localparam int DEF_COUNT_BITS   = 24;

    // Request codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ACTIVATE = 2'd0,
        ACT_LOOKUP   = 2'd1,
        ACT_WINDOW   = 2'd2,
        ACT_UNUSED   = 2'd3
    } t_action;

endpackage

// ----- rtl/row_activation_heavy_hitter_tracker_unit.sv -----
// Top level of the row activation heavy-hitter tracker (Misra-Gries per bank).
// Depends on rahht_pkg; holds the entry memory, spill memory and remainder unit.

// Operation: a request is handled one at a time. An activation or lookup reads the
// NUM_ENTRIES entries of its table through the single read port of the entry
// memory, one per cycle; an activation that finds its row or a candidate entry
// and whose threshold is nonzero then runs the bit-serial remainder unit for the
// aggressor test. Out-of-range, unused and window requests skip the scan. After
// reset, and after every window reset request, a clearing pass writes every
// entry of the entry memory, one per cycle, during which no request is taken.
// Threshold writes are taken at any time the block is idle.
module row_activation_heavy_hitter_tracker_unit #(
    parameter int NUM_ENTRIES  = rahht_pkg::DEF_NUM_ENTRIES,
    parameter int NUM_ROWS     = rahht_pkg::DEF_NUM_ROWS,
    parameter int NUM_BANKS    = rahht_pkg::DEF_NUM_BANKS,
    parameter int NUM_RANKS    = rahht_pkg::DEF_NUM_RANKS,
    parameter int NUM_CHANNELS = rahht_pkg::DEF_NUM_CHANNELS,
    parameter int COUNT_BITS   = rahht_pkg::DEF_COUNT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_threshold_we,
    input  logic [rahht_pkg::THR_W-1:0]  i_threshold_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rahht_pkg::ACTION_W-1:0] i_action,
    input  logic [rahht_pkg::ROW_W-1:0]  i_row,
    input  logic [rahht_pkg::BANK_W-1:0] i_bank,
    input  logic [rahht_pkg::RANK_W-1:0] i_rank,
    input  logic [rahht_pkg::CHAN_W-1:0] i_channel,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_aggressor,
    output logic                         o_tracked,
    output logic                         o_spilled
);
    import rahht_pkg::*;

    localparam int NUM_TABLES = NUM_CHANNELS * NUM_RANKS * NUM_BANKS;
    localparam int TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int ENT_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int ADDR_W     = TBL_W + ENT_W;
    localparam int DEPTH      = NUM_TABLES * (2 ** ENT_W);
    localparam int EW         = 1 + ROW_W + COUNT_BITS;
    localparam int DIVC_W     = $clog2(COUNT_BITS + 1);

    localparam logic [ENT_W-1:0]  LAST_ENT  = ENT_W'(NUM_ENTRIES - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DIV,
        S_RESP
    } t_state;

    // Memories: entries hold {valid, row, count}.
    logic [EW-1:0]         r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_spill_mem [NUM_TABLES];

    t_state r_state;
    logic [THR_W-1:0] r_threshold;

    // Captured request.
    logic             r_lookup;
    logic [ROW_W-1:0] r_row;
    logic [TBL_W-1:0] r_tbl;
    logic             r_clr_after;

    // Scan control and results.
    logic [ENT_W-1:0] r_idx;
    logic             r_issue_done;
    logic             r_chk;
    logic [ENT_W-1:0] r_chk_idx;
    logic             r_hit_found;
    logic [ENT_W-1:0] r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic             r_cand_found;
    logic [ENT_W-1:0] r_cand_idx;
    logic [COUNT_BITS-1:0] r_cand_cnt;

    // Memory read data.
    logic [EW-1:0]         r_rd_data;
    logic [COUNT_BITS-1:0] r_spill_rd;

    // Clearing pass.
    logic [ADDR_W-1:0] r_clr_addr;

    // Remainder unit.
    logic [COUNT_BITS-1:0] r_dvd;
    logic [THR_W-1:0]      r_rem;
    logic [DIVC_W-1:0]     r_divc;

    // Pending result.
    logic r_res_aggr, r_res_tracked, r_res_spilled;
    logic r_o_valid, r_o_aggr, r_o_tracked, r_o_spilled;

    // Combinational helpers.
    logic                  accept;
    logic                  req_ok;
    logic [31:0]           tbl_full;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  we;
    logic [ADDR_W-1:0]     wa;
    logic [EW-1:0]         wd;
    logic                  spill_we;
    logic [TBL_W-1:0]      spill_wa;
    logic [COUNT_BITS-1:0] spill_wd;
    logic                  ent_valid;
    logic [ROW_W-1:0]      ent_row;
    logic [COUNT_BITS-1:0] ent_cnt;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] base_cnt;
    logic [THR_W:0]        div_sh;
    logic [THR_W:0]        div_diff;
    logic                  out_free;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !r_o_valid || i_ready;

    // Table selection and range check of the incoming request.
    assign tbl_full = ((32'(i_channel) * 32'(NUM_RANKS) + 32'(i_rank)) * 32'(NUM_BANKS))
                      + 32'(i_bank);
    assign req_ok   = (32'(i_bank) < 32'(NUM_BANKS)) && (32'(i_rank) < 32'(NUM_RANKS))
                      && (32'(i_channel) < 32'(NUM_CHANNELS)) && (32'(i_row) < 32'(NUM_ROWS));

    // Fields of the entry that arrived from the memory.
    assign ent_valid = r_rd_data[EW-1];
    assign ent_row   = r_rd_data[EW-2 -: ROW_W];
    assign ent_cnt   = r_rd_data[COUNT_BITS-1:0];

    // Saturating increment of the chosen counter.
    always_comb begin
        if (r_hit_found) begin
            base_cnt = r_hit_cnt;
        end else if (r_cand_found) begin
            base_cnt = r_cand_cnt;
        end else begin
            base_cnt = r_spill_rd;
        end
        n_count = (&base_cnt) ? base_cnt : base_cnt + COUNT_BITS'(1);
    end

    // Memory port control.
    always_comb begin
        rd_en    = (r_state == S_SCAN) && !r_issue_done;
        rd_addr  = {r_tbl, r_idx};
        we       = 1'b0;
        wa       = r_clr_addr;
        wd       = '0;
        spill_we = 1'b0;
        spill_wa = r_clr_addr[ADDR_W-1:ENT_W];
        spill_wd = '0;
        if (r_state == S_CLEAR) begin
            we       = 1'b1;
            spill_we = (r_clr_addr[ENT_W-1:0] == '0);
        end else if (r_state == S_FINISH && !r_lookup) begin
            if (r_hit_found) begin
                we = 1'b1;
                wa = {r_tbl, r_hit_idx};
                wd = {1'b1, r_row, n_count};
            end else if (r_cand_found) begin
                we = 1'b1;
                wa = {r_tbl, r_cand_idx};
                wd = {1'b1, r_row, n_count};
            end else begin
                spill_we = 1'b1;
                spill_wa = r_tbl;
                spill_wd = n_count;
            end
        end
    end

    // Entry memory and spill memory.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (spill_we) begin
            r_spill_mem[spill_wa] <= spill_wd;
        end
        r_spill_rd <= r_spill_mem[r_tbl];
    end

    // One step of the restoring remainder.
    assign div_sh   = {r_rem, r_dvd[COUNT_BITS-1]};
    assign div_diff = div_sh - {1'b0, r_threshold};

    // Sequencer, scan bookkeeping and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_threshold  <= THR_RESET;
            r_clr_addr   <= '0;
            r_o_valid    <= 1'b0;
            r_chk        <= 1'b0;
            r_issue_done <= 1'b0;
            r_hit_found  <= 1'b0;
            r_cand_found <= 1'b0;
            r_clr_after  <= 1'b0;
        end else begin
            if (i_threshold_we) begin
                r_threshold <= i_threshold_wdata;
            end
            // The response state reloads the output register itself.
            if (r_o_valid && i_ready && r_state != S_RESP) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_row         <= i_row;
                        r_tbl         <= tbl_full[TBL_W-1:0];
                        r_lookup      <= (i_action == ACT_LOOKUP);
                        r_idx         <= '0;
                        r_issue_done  <= 1'b0;
                        r_chk         <= 1'b0;
                        r_hit_found   <= 1'b0;
                        r_cand_found  <= 1'b0;
                        r_clr_after   <= 1'b0;
                        r_clr_addr    <= '0;
                        r_res_aggr    <= 1'b0;
                        r_res_tracked <= 1'b0;
                        r_res_spilled <= 1'b0;
                        if (i_action == ACT_WINDOW) begin
                            r_clr_after <= 1'b1;
                            r_state     <= S_RESP;
                        end else if ((i_action == ACT_ACTIVATE || i_action == ACT_LOOKUP)
                                     && req_ok) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue one read a cycle and check the entry read the cycle before.
                    if (!r_issue_done) begin
                        r_idx <= r_idx + ENT_W'(1);
                        if (r_idx == LAST_ENT) begin
                            r_issue_done <= 1'b1;
                        end
                    end
                    r_chk     <= rd_en;
                    r_chk_idx <= r_idx;
                    if (r_chk) begin
                        if (ent_valid && ent_row == r_row && !r_hit_found) begin
                            r_hit_found <= 1'b1;
                            r_hit_idx   <= r_chk_idx;
                            r_hit_cnt   <= ent_cnt;
                        end
                        if (ent_cnt == r_spill_rd && !r_cand_found) begin
                            r_cand_found <= 1'b1;
                            r_cand_idx   <= r_chk_idx;
                            r_cand_cnt   <= ent_cnt;
                        end
                        if (r_chk_idx == LAST_ENT) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    // For an activation, write back the counter and, for a tracked row, start the aggressor test.
                    if (r_lookup) begin
                        r_res_tracked <= r_hit_found;
                        r_state       <= S_RESP;
                    end else if (r_hit_found || r_cand_found) begin
                        r_res_tracked <= 1'b1;
                        r_dvd         <= n_count;
                        r_rem         <= '0;
                        r_divc        <= DIVC_W'(COUNT_BITS);
                        r_state       <= (r_threshold == '0) ? S_RESP : S_DIV;
                    end else begin
                        r_res_spilled <= 1'b1;
                        r_state       <= S_RESP;
                    end
                end
                S_DIV: begin
                    r_dvd  <= r_dvd << 1;
                    r_rem  <= div_diff[THR_W] ? div_sh[THR_W-1:0] : div_diff[THR_W-1:0];
                    r_divc <= r_divc - DIVC_W'(1);
                    if (r_divc == DIVC_W'(1)) begin
                        r_state <= S_RESP;
                        r_res_aggr <= div_diff[THR_W] ? (div_sh[THR_W-1:0] == '0)
                                                      : (div_diff[THR_W-1:0] == '0);
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_aggr    <= r_res_aggr;
                        r_o_tracked <= r_res_tracked;
                        r_o_spilled <= r_res_spilled;
                        r_state     <= r_clr_after ? S_CLEAR : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_aggressor = r_o_aggr;
    assign o_tracked   = r_o_tracked;
    assign o_spilled   = r_o_spilled;

    // A request never both retags an entry and spills.
    a_spill_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_spilled && o_tracked))
        else $error("result both spilled and tracked");

    // An aggressor always belongs to a tracked row.
    a_aggr_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_aggressor) |-> o_tracked)
        else $error("aggressor flagged on untracked row");

    // Entry writes happen only in the clearing pass or at write-back.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_CLEAR || r_state == S_FINISH))
        else $error("entry memory written outside write-back");

    // Once a request is taken, no other is taken until it is done.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("second request taken while one is in flight");

endmodule

// ----- verif/row_activation_heavy_hitter_tracker_unit_tb.sv -----
// Self-checking testbench for the row activation heavy-hitter tracker.
// Depends on rahht_pkg and row_activation_heavy_hitter_tracker_unit.
module row_activation_heavy_hitter_tracker_unit_tb;
    import rahht_pkg::*;

    localparam int N_ENT      = 64;
    localparam int N_TABLES   = 64;
    localparam int CNT_W      = 24;
    localparam int CLEAR_WAIT = 4300;
    localparam int END_WAIT   = 200;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic aggressor;
        logic tracked;
        logic spilled;
    } t_answer;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_threshold_we;
    logic [THR_W-1:0]    i_threshold_wdata;
    logic                i_valid;
    logic                o_ready;
    logic [ACTION_W-1:0] i_action;
    logic [ROW_W-1:0]    i_row;
    logic [BANK_W-1:0]   i_bank;
    logic [RANK_W-1:0]   i_rank;
    logic [CHAN_W-1:0]   i_channel;
    logic                o_valid;
    logic                i_ready;
    logic                o_aggressor;
    logic                o_tracked;
    logic                o_spilled;

    row_activation_heavy_hitter_tracker_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_threshold_we(i_threshold_we), .i_threshold_wdata(i_threshold_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_row(i_row), .i_bank(i_bank),
        .i_rank(i_rank), .i_channel(i_channel),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_aggressor(o_aggressor), .o_tracked(o_tracked), .o_spilled(o_spilled)
    );

    // Tracker copy used to predict each answer.
    logic             trk_valid [N_TABLES][N_ENT];
    logic [ROW_W-1:0] trk_row   [N_TABLES][N_ENT];
    logic [CNT_W-1:0] trk_count [N_TABLES][N_ENT];
    logic [CNT_W-1:0] trk_spill [N_TABLES];
    logic [THR_W-1:0] cur_threshold;

    t_answer pending_answers[$];
    int      mismatches;
    int      cycles;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      recv_holdoff;
    int      row_pool_base;

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run-length guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver ready: long hold-off when requested, otherwise random idling.
    always @(posedge i_clk) begin
        if (recv_holdoff > 0) begin
            recv_holdoff <= recv_holdoff - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare every accepted answer with the oldest prediction.
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("Unexpected answer agg=%0b trk=%0b spl=%0b",
                             o_aggressor, o_tracked, o_spilled);
            end else begin
                exp_ans = pending_answers.pop_front();
                if (exp_ans.aggressor !== o_aggressor || exp_ans.tracked !== o_tracked ||
                    exp_ans.spilled !== o_spilled) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Mismatch: expected agg=%0b trk=%0b spl=%0b, got %0b %0b %0b",
                                 exp_ans.aggressor, exp_ans.tracked, exp_ans.spilled,
                                 o_aggressor, o_tracked, o_spilled);
                end
            end
        end
    end

    function automatic void clear_tracker();
        for (int t = 0; t < N_TABLES; t++) begin
            trk_spill[t] = '0;
            for (int e = 0; e < N_ENT; e++) begin
                trk_valid[t][e] = 1'b0;
                trk_row[t][e]   = '0;
                trk_count[t][e] = '0;
            end
        end
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic hits_threshold(logic [CNT_W-1:0] v);
        if (cur_threshold == '0)
            return 1'b0;
        return (v % cur_threshold) == 0;
    endfunction

    // Apply one request to the tracker copy and return its answer.
    function automatic t_answer track_request(t_action act, logic [ROW_W-1:0] row,
                                              logic [BANK_W-1:0] bank,
                                              logic [RANK_W-1:0] rank,
                                              logic [CHAN_W-1:0] chan);
        t_answer ans;
        int tbl;
        int hit;
        ans = '0;
        hit = -1;
        tbl = (int'(chan) * 2 + int'(rank)) * 16 + int'(bank);
        if (act == ACT_WINDOW) begin
            clear_tracker();
            return ans;
        end
        if (act == ACT_UNUSED)
            return ans;
        for (int e = 0; e < N_ENT; e++) begin
            if (hit < 0 && trk_valid[tbl][e] && trk_row[tbl][e] == row)
                hit = e;
        end
        if (act == ACT_LOOKUP) begin
            ans.tracked = (hit >= 0);
        end else if (hit >= 0) begin
            trk_count[tbl][hit] = sat_inc(trk_count[tbl][hit]);
            ans.aggressor = hits_threshold(trk_count[tbl][hit]);
            ans.tracked = 1'b1;
        end else begin
            for (int e = 0; e < N_ENT; e++) begin
                if (!ans.tracked && trk_count[tbl][e] == trk_spill[tbl]) begin
                    trk_row[tbl][e]   = row;
                    trk_valid[tbl][e] = 1'b1;
                    trk_count[tbl][e] = sat_inc(trk_count[tbl][e]);
                    ans.aggressor = hits_threshold(trk_count[tbl][e]);
                    ans.tracked = 1'b1;
                end
            end
            if (!ans.tracked) begin
                trk_spill[tbl] = sat_inc(trk_spill[tbl]);
                ans.spilled = 1'b1;
            end
        end
        return ans;
    endfunction

    // Offer one request, hold it until accepted, then record its answer.
    task automatic send_request(t_action act, logic [ROW_W-1:0] row, logic [BANK_W-1:0] bank,
                                logic [RANK_W-1:0] rank, logic [CHAN_W-1:0] chan);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_row     <= row;
        i_bank    <= bank;
        i_rank    <= rank;
        i_channel <= chan;
        do @(posedge i_clk); while (!o_ready);
        pending_answers.push_back(track_request(act, row, bank, rank, chan));
    endtask

    // Drop valid and wait until every predicted answer has arrived.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    // Threshold write while idle, after any clearing pass has finished.
    task automatic write_threshold(logic [THR_W-1:0] value);
        drain();
        repeat (CLEAR_WAIT) @(posedge i_clk);
        i_threshold_we    <= 1'b1;
        i_threshold_wdata <= value;
        @(posedge i_clk);
        i_threshold_we <= 1'b0;
        cur_threshold = value;
    endtask

    // One random request, mostly activations on a few crowded tables.
    task automatic send_random_request();
        t_action act;
        logic [ROW_W-1:0] row;
        logic [BANK_W-1:0] bank;
        logic [RANK_W-1:0] rank;
        logic [CHAN_W-1:0] chan;
        int pick;
        pick = $urandom_range(999);
        if (pick < 850)      act = ACT_ACTIVATE;
        else if (pick < 985) act = ACT_LOOKUP;
        else if (pick < 992) act = ACT_UNUSED;
        else                 act = ACT_WINDOW;
        if ($urandom_range(99) < 80) begin
            bank = BANK_W'($urandom_range(1));
            rank = '0;
            chan = '0;
        end else begin
            bank = BANK_W'($urandom);
            rank = RANK_W'($urandom);
            chan = CHAN_W'($urandom);
        end
        if ($urandom_range(99) < 80)
            row = ROW_W'(row_pool_base + $urandom_range(90));
        else
            row = ROW_W'($urandom);
        send_request(act, row, bank, rank, chan);
    endtask

    task automatic run_random(int count);
        repeat (count) send_random_request();
    endtask

    // Extremes of every field, every request code, counting to thresholds one and two.
    task automatic test_directed();
        write_threshold(THR_W'(1));
        send_request(ACT_LOOKUP, 16'h0000, 4'd0, 1'b0, 1'b0);
        send_request(ACT_ACTIVATE, 16'h0000, 4'd0, 1'b0, 1'b0);
        send_request(ACT_ACTIVATE, 16'h0000, 4'd0, 1'b0, 1'b0);
        send_request(ACT_LOOKUP, 16'h0000, 4'd0, 1'b0, 1'b0);
        send_request(ACT_ACTIVATE, 16'hFFFF, 4'd15, 1'b1, 1'b1);
        send_request(ACT_LOOKUP, 16'hFFFF, 4'd15, 1'b1, 1'b1);
        send_request(ACT_LOOKUP, 16'hFFFF, 4'd15, 1'b1, 1'b0);
        send_request(ACT_UNUSED, 16'hFFFF, 4'd15, 1'b1, 1'b1);
        send_request(ACT_ACTIVATE, 16'h5555, 4'd10, 1'b0, 1'b1);
        send_request(ACT_ACTIVATE, 16'hAAAA, 4'd5, 1'b1, 1'b0);
        send_request(ACT_WINDOW, 16'h0000, 4'd0, 1'b0, 1'b0);
        send_request(ACT_LOOKUP, 16'h0000, 4'd0, 1'b0, 1'b0);
        send_request(ACT_LOOKUP, 16'hFFFF, 4'd15, 1'b1, 1'b1);
        write_threshold(THR_W'(2));
        for (int k = 0; k < 5; k++)
            send_request(ACT_ACTIVATE, 16'h1234, 4'd3, 1'b0, 1'b0);
        drain();
    endtask

    // Long receiver stall while requests keep coming, then a full pause.
    task automatic test_backpressure();
        recv_holdoff = 3000;
        repeat (20) send_random_request();
        drain();
        run_random(40);
        drain();
    endtask

    // Crowded tables at several thresholds and idling mixes.
    task automatic test_random_phases();
        send_idle_pct = 18; recv_idle_pct = 77;
        write_threshold(THR_W'(3));
        row_pool_base = $urandom_range(65000);
        run_random(500);
        send_idle_pct = 77; recv_idle_pct = 18;
        write_threshold(THR_W'(16777215));
        run_random(350);
        send_idle_pct = 0; recv_idle_pct = 0;
        write_threshold(THR_W'(0));
        run_random(300);
        write_threshold(THR_W'($urandom_range(1, 7)));
        row_pool_base = $urandom_range(65000);
        run_random(350);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_threshold_we = 1'b0;
        i_threshold_wdata = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_action = '0;
        i_row = '0;
        i_bank = '0;
        i_rank = '0;
        i_channel = '0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 18;
        recv_idle_pct = 77;
        recv_holdoff = 0;
        row_pool_base = 0;
        cur_threshold = THR_RESET;
        clear_tracker();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
